>>> design/hexu_pkg.sv
package hexu_pkg;

    localparam int CMD_DEPTH_DEF = 4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EXP_HEX  = 2'd1;
    localparam logic [1:0] STATUS_TOO_HIGH = 2'd2;

    localparam logic [7:0] HEAD_2B   = 8'b1100_0000;
    localparam logic [7:0] HEAD_3B   = 8'b1110_0000;
    localparam logic [7:0] HEAD_4B   = 8'b1111_0000;
    localparam logic [7:0] HEAD_5B   = 8'b1111_1000;
    localparam logic [7:0] HEAD_6B   = 8'b1111_1100;
    localparam logic [7:0] CONT_MARK = 8'h80;
    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [3:0] WIDE_MAX  = 4'd7;

    localparam logic [7:0] CHR_X = 8'h78;
    localparam logic [7:0] CHR_U = 8'h75;

    typedef struct packed {
        logic [7:0] ch;
        logic       escape_start;
        logic       text_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } out_word_t;

    // One entry of the front-to-back queue: an error report or a code point
    // with the number of continuation bytes that follow its lead byte.
    typedef struct packed {
        logic        is_err;
        logic [1:0]  status;
        logic [2:0]  tail;
        logic [30:0] value;
    } cmd_t;

endpackage

>>> design/hexu_front.sv
module hexu_front
    import hexu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_word_t item,
    output logic     cmd_push,
    output cmd_t     cmd
);

    typedef enum logic [1:0] {PH_IDLE, PH_COLLECT} phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  digits_left_reg, digits_left_next;
    logic        wide_first_reg, wide_first_next;
    logic [30:0] code_value_reg, code_value_next;

    logic        is_hex;
    logic [3:0]  digit;
    logic [30:0] new_value;
    logic [3:0]  digits_dec;
    logic [2:0]  new_tail;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (item.ch >= 8'h30 && item.ch <= 8'h39)
            digit = item.ch[3:0];
        else if ((item.ch >= 8'h61 && item.ch <= 8'h66) ||
                 (item.ch >= 8'h41 && item.ch <= 8'h46))
            digit = item.ch[3:0] + 4'd9;
        else
            is_hex = 1'b0;
    end

    assign new_value  = {code_value_reg[26:0], digit};
    assign digits_dec = (digits_left_reg != 4'd0) ? digits_left_reg - 4'd1 : 4'd0;

    always_comb
    begin
        if (new_value[30:26] != 5'd0)
            new_tail = 3'd5;
        else if (new_value[25:21] != 5'd0)
            new_tail = 3'd4;
        else if (new_value[20:16] != 5'd0)
            new_tail = 3'd3;
        else if (new_value[15:11] != 5'd0)
            new_tail = 3'd2;
        else if (new_value[10:7] != 4'd0)
            new_tail = 3'd1;
        else
            new_tail = 3'd0;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        digits_left_next = digits_left_reg;
        wide_first_next  = wide_first_reg;
        code_value_next  = code_value_reg;
        cmd_push         = 1'b0;
        cmd.is_err       = 1'b1;
        cmd.status       = STATUS_EXP_HEX;
        cmd.tail         = 3'd0;
        cmd.value        = new_value;
        if (accept)
        begin
            if (item.text_end)
            begin
                if (phase_reg == PH_COLLECT)
                begin
                    cmd_push         = 1'b1;
                    phase_next       = PH_IDLE;
                    digits_left_next = 4'd0;
                    wide_first_next  = 1'b0;
                end
            end
            else if (item.escape_start)
            begin
                case (item.ch)
                    CHR_X:
                    begin
                        digits_left_next = 4'd2;
                        wide_first_next  = 1'b0;
                    end
                    CHR_U:
                    begin
                        digits_left_next = 4'd4;
                        wide_first_next  = 1'b0;
                    end
                    default:
                    begin
                        digits_left_next = 4'd8;
                        wide_first_next  = 1'b1;
                    end
                endcase
                code_value_next = '0;
                phase_next      = PH_COLLECT;
            end
            else if (phase_reg == PH_COLLECT)
            begin
                if (!is_hex || (wide_first_reg && digit > WIDE_MAX))
                begin
                    cmd_push         = 1'b1;
                    cmd.status       = is_hex ? STATUS_TOO_HIGH : STATUS_EXP_HEX;
                    phase_next       = PH_IDLE;
                    digits_left_next = 4'd0;
                    wide_first_next  = 1'b0;
                end
                else
                begin
                    wide_first_next  = 1'b0;
                    code_value_next  = new_value;
                    digits_left_next = digits_dec;
                    if (digits_dec == 4'd0)
                    begin
                        phase_next = PH_IDLE;
                        cmd_push   = 1'b1;
                        cmd.is_err = 1'b0;
                        cmd.status = STATUS_OK;
                        cmd.tail   = new_tail;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            digits_left_reg <= 4'd0;
            wide_first_reg  <= 1'b0;
            code_value_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            digits_left_reg <= digits_left_next;
            wide_first_reg  <= wide_first_next;
            code_value_reg  <= code_value_next;
        end
    end

endmodule

>>> design/hexu_cmd_fifo.sv
module hexu_cmd_fifo
    import hexu_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

>>> design/hexu_back.sv
module hexu_back
    import hexu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_empty,
    output logic      cmd_pop,
    output out_word_t result,
    output logic      empty,
    input  logic      pop
);

    logic [2:0] cnt_reg;
    logic       valid_reg;
    out_word_t  result_reg;

    logic       take;
    logic       byte_last;
    logic [2:0] sel;
    logic [5:0] seg;
    logic [7:0] head_mask;
    out_word_t  word_next;

    assign take      = (!valid_reg || pop) && !cmd_empty;
    assign byte_last = (cnt_reg == cmd.tail);
    assign cmd_pop   = take && byte_last;
    assign sel       = (cnt_reg == 3'd0) ? cmd.tail : cmd.tail - cnt_reg;

    always_comb
    begin
        case (sel)
            3'd0:    seg = cmd.value[5:0];
            3'd1:    seg = cmd.value[11:6];
            3'd2:    seg = cmd.value[17:12];
            3'd3:    seg = cmd.value[23:18];
            3'd4:    seg = cmd.value[29:24];
            3'd5:    seg = {5'd0, cmd.value[30]};
            default: seg = 6'd0;
        endcase
    end

    always_comb
    begin
        case (cmd.tail)
            3'd1:    head_mask = HEAD_2B;
            3'd2:    head_mask = HEAD_3B;
            3'd3:    head_mask = HEAD_4B;
            3'd4:    head_mask = HEAD_5B;
            3'd5:    head_mask = HEAD_6B;
            default: head_mask = 8'd0;
        endcase
    end

    always_comb
    begin
        word_next.last   = byte_last;
        word_next.status = cmd.status;
        if (cmd.is_err)
            word_next.out_byte = 8'd0;
        else if (cmd.tail == 3'd0)
            word_next.out_byte = {1'b0, cmd.value[6:0]};
        else if (cnt_reg == 3'd0)
            word_next.out_byte = head_mask | {2'b00, seg};
        else
            word_next.out_byte = CONT_MARK | ({2'b00, seg} & CONT_MASK);
    end

    assign result = result_reg;
    assign empty  = !valid_reg;

    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= 1'b1;
                cnt_reg   <= byte_last ? 3'd0 : cnt_reg + 3'd1;
            end
            else if (pop)
                valid_reg <= 1'b0;
        end
    end

endmodule

>>> design/hex_escape_to_utf8_core.sv
// Channel   Handshake            Word        Direction
// -------   ------------------   ---------   ---------
// item      push / full          in_word_t   into block
// result    pop / empty          out_word_t  out of block
//
// One character word is taken per cycle while full is low; the front
// decodes it in the same cycle and queues at most one command.
// The back turns each command into 1 to 6 result words, one per cycle
// while the result register is empty or being popped.
// Reset clears the escape state, the command queue and the result valid flag.
// A stalled result side fills the command queue; full then rises.
module hex_escape_to_utf8_core
    import hexu_pkg::*;
#(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_word_t  item,
    output logic      empty,
    input  logic      pop,
    output out_word_t result
);

    logic cmd_push;
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_in;
    cmd_t cmd_head;

    // Front: track escape state, classify each character word.
    hexu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (push && !full),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // Decouple front and back so each side stalls on its own.
    hexu_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (full),
        .pop       (cmd_pop),
        .pop_data  (cmd_head),
        .empty     (cmd_empty)
    );

    // Back: expand each command into UTF-8 bytes or an error word behind one output register.
    hexu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

>>> bench/hex_escape_to_utf8_core_tb.sv
module hex_escape_to_utf8_core_tb;
    import hexu_pkg::*;

    // Number of random input words after the directed table.
    localparam int RANDOM_WORDS = 352;
    // Cycles to keep watching after the last expected word has come.
    localparam int SETTLE_CYCLES = 24;
    // Hard stop for the whole run, in time units.
    localparam int RUN_LIMIT = 480_000;

    // One stimulus row: the character word, plus an optional typed-in
    // expectation that replaces the predicted bytes for that row.
    typedef struct packed {
        in_word_t        word;
        logic            use_fixed;
        logic [2:0]      n_fixed;
        out_word_t [5:0] fixed;
    } char_row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_word_t  item;
    logic      empty;
    logic      pop;
    out_word_t result;

    hex_escape_to_utf8_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Predictor state: mirrors the escape decoder of the block.
    logic        esc_collecting;
    logic [3:0]  esc_digits_left;
    logic        esc_wide_first;
    logic [30:0] esc_code_value;

    // UTF-8 words still owed by the block, oldest first.
    out_word_t utf8_pending[$];
    char_row_t char_table[$];

    int words_sent;
    int bytes_checked;
    int error_reports;
    int code_points;
    int fails;
    int directed_words;

    //--------------------------------------------------------------------
    // Clock and run limit
    //--------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("timeout at %0t with %0d words still owed", $time, utf8_pending.size());
        $display("hex_escape_to_utf8_core_tb NOT OK");
        $finish;
    end

    //--------------------------------------------------------------------
    // Predictor
    //--------------------------------------------------------------------

    // Decode one character as a hex digit; bit 4 flags a valid digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    // Split a code point into 1 to 6 bytes of the legacy 31-bit form.
    function automatic int utf8_bytes(input logic [30:0] v, output out_word_t [5:0] seq);
        logic [7:0] head;
        int         tail;
        logic [30:0] chunk;
        seq = '0;
        if (v < 31'h80)
        begin
            seq[0] = '{out_byte: v[7:0], last: 1'b1, status: STATUS_OK};
            return 1;
        end
        if (v < (31'd1 << 11))
        begin
            head = HEAD_2B;
            tail = 1;
        end
        else if (v < (31'd1 << 16))
        begin
            head = HEAD_3B;
            tail = 2;
        end
        else if (v < (31'd1 << 21))
        begin
            head = HEAD_4B;
            tail = 3;
        end
        else if (v < (31'd1 << 26))
        begin
            head = HEAD_5B;
            tail = 4;
        end
        else
        begin
            head = HEAD_6B;
            tail = 5;
        end
        chunk = v >> (6 * tail);
        seq[0] = '{out_byte: head | chunk[7:0], last: 1'b0, status: STATUS_OK};
        for (int k = 1; k <= tail; k++)
        begin
            chunk = v >> (6 * (tail - k));
            seq[k] = '{out_byte: CONT_MARK | (chunk[7:0] & CONT_MASK),
                       last: (k == tail), status: STATUS_OK};
        end
        return tail + 1;
    endfunction

    // Advance the decoder by one accepted word; return the bytes it causes.
    function automatic int decode_char(input in_word_t w, output out_word_t [5:0] seq);
        logic [4:0] nib;
        logic [1:0] err;
        seq = '0;
        err = STATUS_OK;
        if (w.text_end)
        begin
            // End of text wins over a selector; only a running escape reports.
            if (esc_collecting)
                err = STATUS_EXP_HEX;
        end
        else if (w.escape_start)
        begin
            // Drop any running escape and start over.
            esc_wide_first  = 1'b0;
            if (w.ch == CHR_X)
                esc_digits_left = 4'd2;
            else if (w.ch == CHR_U)
                esc_digits_left = 4'd4;
            else
            begin
                esc_digits_left = 4'd8;
                esc_wide_first  = 1'b1;
            end
            esc_code_value = '0;
            esc_collecting = 1'b1;
        end
        else if (esc_collecting)
        begin
            nib = hex_nibble(w.ch);
            if (!nib[4])
                err = STATUS_EXP_HEX;
            else if (esc_wide_first && nib[3:0] > WIDE_MAX)
                err = STATUS_TOO_HIGH;
            else
            begin
                esc_wide_first = 1'b0;
                esc_code_value = {esc_code_value[26:0], nib[3:0]};
                if (esc_digits_left != 0)
                    esc_digits_left = esc_digits_left - 4'd1;
                if (esc_digits_left == 0)
                begin
                    esc_collecting = 1'b0;
                    return utf8_bytes(esc_code_value, seq);
                end
            end
        end
        if (err != STATUS_OK)
        begin
            // An error leaves the gathered value alone but ends the escape.
            seq[0] = '{out_byte: 8'h00, last: 1'b1, status: err};
            esc_collecting  = 1'b0;
            esc_digits_left = '0;
            esc_wide_first  = 1'b0;
            return 1;
        end
        return 0;
    endfunction

    //--------------------------------------------------------------------
    // Traffic helpers
    //--------------------------------------------------------------------

    // Hold both sides busy through a stretch in the middle of the run.
    function automatic bit idle_roll();
        if (words_sent >= 200 && words_sent < 300)
            return 1'b0;
        return $urandom_range(0, 99) < 26;
    endfunction

    function automatic char_row_t plain(input logic [7:0] c, input logic st, input logic te);
        char_row_t r;
        r = '0;
        r.word = '{ch: c, escape_start: st, text_end: te};
        return r;
    endfunction

    // Queue a directed row; nfix > 0 types in the expected bytes, first
    // byte most significant, with last set on the final one.
    task automatic add_row(input logic [7:0] c, input logic st, input logic te,
                           input int nfix, input logic [47:0] fix_bytes,
                           input logic [1:0] fix_status);
        char_row_t r;
        r = plain(c, st, te);
        r.use_fixed = (nfix > 0);
        r.n_fixed = 3'(nfix);
        for (int k = 0; k < nfix; k++)
            r.fixed[k] = '{out_byte: fix_bytes[8 * (nfix - 1 - k) +: 8],
                           last: (k == nfix - 1), status: fix_status};
        char_table.push_back(r);
    endtask

    // Present one word from the falling edge, hold it until the block takes
    // it, then record what that word should produce.
    task automatic send_row(input char_row_t r);
        out_word_t [5:0] seq;
        int n;
        @(negedge clk);
        while (idle_roll())
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= r.word;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n = decode_char(r.word, seq);
        if (r.use_fixed)
        begin
            n = r.n_fixed;
            seq = r.fixed;
        end
        for (int k = 0; k < n; k++)
            utf8_pending.push_back(seq[k]);
        words_sent++;
    endtask

    // Stop sending until the block has delivered every owed word.
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (utf8_pending.size() != 0)
            @(negedge clk);
    endtask

    // Hex digit character for a nibble, letters in random case.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return "0" + 8'(nib);
        if ($urandom_range(0, 1))
            return "a" + 8'(nib - 4'd10);
        return "A" + 8'(nib - 4'd10);
    endfunction

    // Send one escape: selector, then digits of a value of random bit length.
    // A broken escape swaps one digit for a fault and stops there.
    task automatic send_escape(input bit broken);
        logic [7:0]  sel;
        logic [7:0]  junk;
        logic [31:0] mask;
        logic [30:0] val;
        logic [3:0]  nib;
        int ndig;
        int len;
        int bad_at;
        int fault;
        case ($urandom_range(0, 2))
            0:
            begin
                sel = CHR_X;
                ndig = 2;
            end
            1:
            begin
                sel = CHR_U;
                ndig = 4;
            end
            default:
            begin
                do
                    sel = 8'($urandom_range(0, 255));
                while (sel == CHR_X || sel == CHR_U);
                ndig = 8;
            end
        endcase
        len = $urandom_range(0, (ndig == 8) ? 31 : 4 * ndig);
        mask = (32'd1 << len) - 32'd1;
        val = 31'($urandom & mask);
        bad_at = broken ? $urandom_range(0, ndig - 1) : ndig;
        fault = $urandom_range(0, 3);
        send_row(plain(sel, 1'b1, 1'b0));
        for (int i = 0; i < ndig; i++)
        begin
            nib = 4'(val >> (4 * (ndig - 1 - i)));
            if (i == bad_at)
            begin
                case (fault)
                    1:
                        send_row(plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
                    2:
                        send_row(plain(8'($urandom_range(0, 255)), 1'b1, 1'b0));
                    default:
                    begin
                        if (fault == 3 && ndig == 8 && i == 0)
                            junk = hex_char(4'($urandom_range(8, 15)));
                        else
                            do
                                junk = 8'($urandom_range(0, 255));
                            while (hex_nibble(junk) != 5'd0);
                        send_row(plain(junk, 1'b0, 1'b0));
                    end
                endcase
                return;
            end
            send_row(plain(hex_char(nib), 1'b0, 1'b0));
        end
    endtask

    //--------------------------------------------------------------------
    // Result side: random pop, checked at the rising edge
    //--------------------------------------------------------------------
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= !idle_roll();
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && pop && !empty)
        begin
            if (utf8_pending.size() == 0)
            begin
                $display("%0t: unexpected word byte=%h last=%b status=%0d",
                         $time, result.out_byte, result.last, result.status);
                fails++;
            end
            else
            begin
                want = utf8_pending.pop_front();
                bytes_checked++;
                if (want.status != STATUS_OK)
                    error_reports++;
                else if (want.last)
                    code_points++;
                if (result.out_byte !== want.out_byte)
                begin
                    $display("%0t: out_byte expected %h got %h", $time, want.out_byte,
                             result.out_byte);
                    fails++;
                end
                if (result.last !== want.last)
                begin
                    $display("%0t: last expected %b got %b", $time, want.last, result.last);
                    fails++;
                end
                if (result.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             result.status);
                    fails++;
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // Stimulus
    //--------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        words_sent = 0;
        bytes_checked = 0;
        error_reports = 0;
        code_points = 0;
        fails = 0;
        esc_collecting = 1'b0;
        esc_digits_left = '0;
        esc_wide_first = 1'b0;
        esc_code_value = '0;

        // Directed table. Rows with nfix 0 go through the predictor.
        // End of text with a selector while idle: end wins, nothing comes out.
        add_row(8'hFF, 1'b1, 1'b1, 0, 48'h0, STATUS_OK);
        // Stray character while idle: ignored.
        add_row("A", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        // Two-digit escape, largest single-byte code point.
        add_row("x", 1'b1, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("7", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("F", 1'b0, 1'b0, 1, 48'h7F, STATUS_OK);
        // New selector mid-escape drops the first one; zero code point.
        add_row("x", 1'b1, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("0", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("x", 1'b1, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("0", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("0", 1'b0, 1'b0, 1, 48'h00, STATUS_OK);
        // Eight-digit escape whose first digit is above seven.
        add_row(8'hFF, 1'b1, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("8", 1'b0, 1'b0, 1, 48'h00, STATUS_TOO_HIGH);
        // Non-hex character inside an escape.
        add_row("u", 1'b1, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("g", 1'b0, 1'b0, 1, 48'h00, STATUS_EXP_HEX);
        // End of text while digits are still awaited.
        add_row("u", 1'b1, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("1", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row(8'h00, 1'b0, 1'b1, 1, 48'h00, STATUS_EXP_HEX);
        // Largest 31-bit value, six bytes, mixed-case digits.
        add_row(8'h00, 1'b1, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("7", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("f", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("F", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("f", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("F", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("f", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("F", 1'b0, 1'b0, 0, 48'h0, STATUS_OK);
        add_row("F", 1'b0, 1'b0, 6, 48'hFDBFBFBFBFBF, STATUS_OK);

        // Hold reset, then release it on a falling edge.
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        foreach (char_table[i])
            send_row(char_table[i]);
        directed_words = words_sent;

        // Let the block empty out before the random part.
        drain_results();

        // Mostly well-formed escapes, mixed at random with broken ones, loose noise words and drains.
        while (words_sent < directed_words + RANDOM_WORDS)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                    send_escape(1'b0);
                14, 15, 16:
                    send_escape(1'b1);
                17, 18:
                    send_row(plain(8'($urandom_range(0, 255)), 1'($urandom_range(0, 4) == 0),
                                   1'($urandom_range(0, 5) == 0)));
                default:
                    drain_results();
            endcase
        end

        // Wait out everything still owed, then watch for strays.
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("sent %0d character words (%0d directed); checked %0d output bytes",
                 words_sent, directed_words, bytes_checked);
        $display("complete code points %0d, error reports %0d, mismatches %0d",
                 code_points, error_reports, fails);
        if (fails == 0)
            $display("hex_escape_to_utf8_core_tb OK");
        else
            $display("hex_escape_to_utf8_core_tb NOT OK");
        $finish;
    end

endmodule
